FILE: rtl/lpcp_pkg.sv
// lpcp_pkg: shared types and constants of the lidar point camera projector
// no dependencies; imported by every module of the block but lpcp_ram
`default_nettype none

package lpcp_pkg;

  // request kinds carried on the slave-side tuser
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  // configuration register indexes
  localparam int NUM_REGS      = 8;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_W         = 64;
  localparam int REG_MIN_RANGE = 6;
  localparam int REG_MAX_RANGE = 7;

  // quotient width of the projected coordinates, sum and divider widths
  localparam int QUOT_BITS = 12;
  localparam int SUM_W     = 67;
  localparam int DIV_W     = SUM_W + QUOT_BITS;

  typedef logic [NUM_REGS-1:0][CFG_W-1:0] cfg_bank_t;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [8:0]         row;
    logic [9:0]         col;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
  } item_t;

  typedef struct packed {
    logic valid;
    logic keep;
  } ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/lpcp_ram.sv
// lpcp_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module lpcp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 307200,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lpcp_project.sv
// lpcp_project: cone, range and zero w filters and the 3x4 projection, five stages
// depends on lpcp_pkg
`default_nettype none

module lpcp_project #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire lpcp_pkg::item_t               in_item,
  input  wire lpcp_pkg::cfg_bank_t           cfg,
  output lpcp_pkg::ctrl_t                    out_ctrl,
  output lpcp_pkg::item_t                    out_item,
  output logic signed [lpcp_pkg::SUM_W-1:0]  num_u,
  output logic signed [lpcp_pkg::SUM_W-1:0]  num_v,
  output logic signed [lpcp_pkg::SUM_W-1:0]  den
);
  import lpcp_pkg::*;

  function automatic logic signed [31:0] coef(input cfg_bank_t bank, input int r, input int c);
    logic [63:0] pair;
    pair = bank[r*2 + c/2];
    return (c % 2 == 1) ? pair[63:32] : pair[31:0];
  endfunction

  ctrl_t c1, c2, c3, c4, c5;
  item_t i1, i2, i3, i4, i5;

  // stage 1: cone test
  logic signed [32:0] x_ext, y_ext, ay;
  logic cone;
  always_comb begin
    x_ext = {in_item.x[31], in_item.x};
    y_ext = {in_item.y[31], in_item.y};
    ay    = y_ext[32] ? -y_ext : y_ext;
    cone  = (x_ext > 33'sd0) && (ay <= x_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1.valid <= 1'b0;
    end else if (en) begin
      c1.valid <= in_valid;
      c1.keep  <= (in_item.cmd == CMD_POINT) && cone;
      i1       <= in_item;
    end
  end

  // stage 2: squares and matrix products
  logic [31:0] mx, my, mz;
  logic [63:0] sq [3];
  logic signed [63:0] prod [3][4];
  always_comb begin
    mx = i1.x[31] ? (~i1.x + 32'd1) : i1.x;
    my = i1.y[31] ? (~i1.y + 32'd1) : i1.y;
    mz = i1.z[31] ? (~i1.z + 32'd1) : i1.z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c2.valid <= 1'b0;
    end else if (en) begin
      c2    <= c1;
      i2    <= i1;
      sq[0] <= mx * mx;
      sq[1] <= my * my;
      sq[2] <= mz * mz;
      for (int r = 0; r < 3; r++) begin
        prod[r][0] <= coef(cfg, r, 0) * i1.x;
        prod[r][1] <= coef(cfg, r, 1) * i1.y;
        prod[r][2] <= coef(cfg, r, 2) * i1.z;
        prod[r][3] <= 64'(coef(cfg, r, 3)) <<< COORD_FRAC_BITS;
      end
    end
  end

  // stage 3: squared range and partial sums
  logic [63:0] r2;
  logic signed [64:0] pa [3];
  logic signed [64:0] pb [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      c3.valid <= 1'b0;
    end else if (en) begin
      c3 <= c2;
      i3 <= i2;
      r2 <= sq[0] + sq[1] + sq[2];
      for (int r = 0; r < 3; r++) begin
        pa[r] <= {prod[r][0][63], prod[r][0]} + {prod[r][1][63], prod[r][1]};
        pb[r] <= {prod[r][2][63], prod[r][2]} + {prod[r][3][63], prod[r][3]};
      end
    end
  end

  // stage 4: range window and homogeneous sums
  logic signed [SUM_W-1:0] hs [3];
  logic in_range;
  assign in_range = (cfg[REG_MIN_RANGE] < r2) && (r2 < cfg[REG_MAX_RANGE]);
  always_ff @(posedge clk) begin
    if (rst) begin
      c4.valid <= 1'b0;
    end else if (en) begin
      c4.valid <= c3.valid;
      c4.keep  <= c3.keep && in_range;
      i4       <= i3;
      for (int r = 0; r < 3; r++) begin
        hs[r] <= {{2{pa[r][64]}}, pa[r]} + {{2{pb[r][64]}}, pb[r]};
      end
    end
  end

  // stage 5: drop zero w, make the divisor positive
  logic w_neg;
  assign w_neg = hs[2][SUM_W-1];
  always_ff @(posedge clk) begin
    if (rst) begin
      c5.valid <= 1'b0;
    end else if (en) begin
      c5.valid <= c4.valid;
      c5.keep  <= c4.keep && (hs[2] != '0);
      i5       <= i4;
      num_u    <= w_neg ? -hs[0] : hs[0];
      num_v    <= w_neg ? -hs[1] : hs[1];
      den      <= w_neg ? -hs[2] : hs[2];
    end
  end

  assign out_ctrl = c5;
  assign out_item = i5;

endmodule

`default_nettype wire

FILE: rtl/lpcp_divide.sv
// lpcp_divide: bound check and restoring division, one quotient bit per stage
// depends on lpcp_pkg
`default_nettype none

module lpcp_divide (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire lpcp_pkg::ctrl_t                    in_ctrl,
  input  wire lpcp_pkg::item_t                    in_item,
  input  wire logic signed [lpcp_pkg::SUM_W-1:0]  num_u,
  input  wire logic signed [lpcp_pkg::SUM_W-1:0]  num_v,
  input  wire logic signed [lpcp_pkg::SUM_W-1:0]  den,
  output lpcp_pkg::ctrl_t                         out_ctrl,
  output lpcp_pkg::item_t                         out_item,
  output logic [lpcp_pkg::QUOT_BITS-1:0]          quo_u,
  output logic [lpcp_pkg::QUOT_BITS-1:0]          quo_v
);
  import lpcp_pkg::*;

  ctrl_t               ctrl  [QUOT_BITS+1];
  item_t               item  [QUOT_BITS+1];
  logic [DIV_W-1:0]    rem_u [QUOT_BITS+1];
  logic [DIV_W-1:0]    rem_v [QUOT_BITS+1];
  logic [DIV_W-1:0]    dsr   [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] q_u  [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] q_v  [QUOT_BITS+1];

  // quotient must be non-negative and below 2^QUOT_BITS
  logic [DIV_W-1:0] nu_w, nv_w, den_top;
  logic bound_ok;
  always_comb begin
    nu_w     = {{QUOT_BITS{1'b0}}, num_u};
    nv_w     = {{QUOT_BITS{1'b0}}, num_v};
    den_top  = {den, {QUOT_BITS{1'b0}}};
    bound_ok = !num_u[SUM_W-1] && !num_v[SUM_W-1] && (nu_w < den_top) && (nv_w < den_top);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl[0].valid <= 1'b0;
    end else if (en) begin
      ctrl[0].valid <= in_ctrl.valid;
      ctrl[0].keep  <= in_ctrl.keep && bound_ok;
      item[0]       <= in_item;
      rem_u[0]      <= nu_w;
      rem_v[0]      <= nv_w;
      dsr[0]        <= {{QUOT_BITS{1'b0}}, den};
      q_u[0]        <= '0;
      q_v[0]        <= '0;
    end
  end

  for (genvar gi = 0; gi < QUOT_BITS; gi++) begin : g_step
    localparam int B = QUOT_BITS - 1 - gi;
    logic [DIV_W-1:0] t;
    assign t = dsr[gi] << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        ctrl[gi+1].valid <= 1'b0;
      end else if (en) begin
        ctrl[gi+1] <= ctrl[gi];
        item[gi+1] <= item[gi];
        dsr[gi+1]  <= dsr[gi];
        if (rem_u[gi] >= t) begin
          rem_u[gi+1] <= rem_u[gi] - t;
          q_u[gi+1]   <= q_u[gi] | (QUOT_BITS'(1) << B);
        end else begin
          rem_u[gi+1] <= rem_u[gi];
          q_u[gi+1]   <= q_u[gi];
        end
        if (rem_v[gi] >= t) begin
          rem_v[gi+1] <= rem_v[gi] - t;
          q_v[gi+1]   <= q_v[gi] | (QUOT_BITS'(1) << B);
        end else begin
          rem_v[gi+1] <= rem_v[gi];
          q_v[gi+1]   <= q_v[gi];
        end
      end
    end
  end

  assign out_ctrl = ctrl[QUOT_BITS];
  assign out_item = item[QUOT_BITS];
  assign quo_u    = q_u[QUOT_BITS];
  assign quo_v    = q_v[QUOT_BITS];

endmodule

`default_nettype wire

FILE: rtl/lidar_point_camera_projector.sv
// lidar_point_camera_projector: top level, frame store, address stage and output register
// depends on lpcp_pkg, lpcp_project, lpcp_divide and lpcp_ram
//
// usage
//  - slave side takes one request per cycle while ready: tuser = 0 writes a bgr pixel
//    into the frame store, tuser = 1 projects one lidar point through the 3x4 matrix
//  - a point inside the 45 degree cone, inside the range window, with w not zero
//    and landing inside the image leaves on the master side with the colour
//    stored at its pixel; every other request gives no result
//  - pixel writes and point reads meet the frame store at the same stage, so a
//    point always sees exactly the pixels written by earlier requests
//  - throughput is one request per cycle while s_tready is high; the depth is set by
//    five projection stages, the bound stage and 12 quotient stages of the divider,
//    the address stage and the output register
//  - the whole pipeline advances together; s_tready is low only while a result
//    waits in the output register and m_tready is low, nothing is lost or repeated
//  - reset clears the valid bits and the configuration registers; the frame store
//    is not cleared, reading a never written pixel gives undefined colour
//  - configuration is written through cfg_wen/cfg_index/cfg_data while idle
`default_nettype none

module lidar_point_camera_projector #(
  parameter int IMAGE_WIDTH     = 640,
  parameter int IMAGE_HEIGHT    = 480,
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // slave side
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // tdata: point_x, point_y, point_z, pixel_row, pixel_column, pixel_blue,
  //        pixel_green, pixel_red, zero fill to 144 bits
  input  wire logic [143:0]                      s_tdata,
  // tuser: cmd
  input  wire logic                              s_tuser,
  // master side
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // tdata: out_x, out_y, out_z, out_red, out_green, out_blue
  output logic [119:0]                           m_tdata,
  // configuration
  input  wire logic                              cfg_wen,
  input  wire logic [lpcp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [lpcp_pkg::CFG_W-1:0]        cfg_data
);
  import lpcp_pkg::*;

  localparam int DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MUL_W  = QUOT_BITS + 13;

  // configuration registers
  cfg_bank_t cfg;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wen) begin
      cfg[cfg_index] <= cfg_data;
    end
  end

  // global advance: output register free or being drained
  logic en;
  logic ovalid;
  assign en       = !ovalid || m_tready;
  assign s_tready = en;

  item_t in_item;
  always_comb begin
    in_item.cmd   = s_tuser;
    in_item.x     = s_tdata[31:0];
    in_item.y     = s_tdata[63:32];
    in_item.z     = s_tdata[95:64];
    in_item.row   = s_tdata[104:96];
    in_item.col   = s_tdata[114:105];
    in_item.blue  = s_tdata[122:115];
    in_item.green = s_tdata[130:123];
    in_item.red   = s_tdata[138:131];
  end

  ctrl_t p_ctrl, d_ctrl;
  item_t p_item, d_item;
  logic signed [SUM_W-1:0] num_u, num_v, den;
  logic [QUOT_BITS-1:0] quo_u, quo_v;

  lpcp_project #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_project (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .in_item  (in_item),
    .cfg      (cfg),
    .out_ctrl (p_ctrl),
    .out_item (p_item),
    .num_u    (num_u),
    .num_v    (num_v),
    .den      (den)
  );

  lpcp_divide u_divide (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_ctrl  (p_ctrl),
    .in_item  (p_item),
    .num_u    (num_u),
    .num_v    (num_v),
    .den      (den),
    .out_ctrl (d_ctrl),
    .out_item (d_item),
    .quo_u    (quo_u),
    .quo_v    (quo_v)
  );

  // address stage: frame bounds and linear address for both request kinds
  logic [QUOT_BITS-1:0] sel_row, sel_col;
  logic [MUL_W-1:0]     addr_full;
  logic                 pt_in, px_in, is_point;
  always_comb begin
    is_point  = (d_item.cmd == CMD_POINT);
    pt_in     = ({1'b0, quo_u} < (QUOT_BITS+1)'(IMAGE_WIDTH))
             && ({1'b0, quo_v} < (QUOT_BITS+1)'(IMAGE_HEIGHT));
    px_in     = (int'(d_item.row) < IMAGE_HEIGHT) && (int'(d_item.col) < IMAGE_WIDTH);
    sel_row   = is_point ? quo_v : QUOT_BITS'(d_item.row);
    sel_col   = is_point ? quo_u : QUOT_BITS'(d_item.col);
    addr_full = MUL_W'(sel_row) * MUL_W'(IMAGE_WIDTH) + MUL_W'(sel_col);
  end

  logic              va, wr_a, rd_a;
  logic [ADDR_W-1:0] addr_a;
  item_t             item_a;
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va     <= d_ctrl.valid;
      wr_a   <= !is_point && px_in;
      rd_a   <= is_point && d_ctrl.keep && pt_in;
      addr_a <= ADDR_W'(addr_full);
      item_a <= d_item;
    end
  end

  // frame store access; read data lines up with the output register
  logic [23:0] pix;
  lpcp_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (en && va && wr_a),
    .waddr (addr_a),
    .wdata ({item_a.red, item_a.green, item_a.blue}),
    .re    (en),
    .raddr (addr_a),
    .rdata (pix)
  );

  // output register
  logic signed [31:0] ox, oy, oz;
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (en) begin
      ovalid <= va && rd_a;
      ox     <= item_a.x;
      oy     <= item_a.y;
      oz     <= item_a.z;
    end
  end

  // colour stored b, g, r from the low bits up
  assign m_tvalid = ovalid;
  assign m_tdata  = {pix[7:0], pix[15:8], pix[23:16], oz, oy, ox};

  // a stage holds a pixel write or a point read, never both
  a_excl: assert property (@(posedge clk) disable iff (rst) va |-> !(wr_a && rd_a))
    else $error("address stage holds both a write and a read");

  // any frame access stays inside the store
  a_addr: assert property (@(posedge clk) disable iff (rst)
    va && (wr_a || rd_a) |-> (int'(addr_a) < DEPTH))
    else $error("frame address out of range");

  // a stall freezes the address stage
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(va) && $stable(addr_a) && $stable(rd_a))
    else $error("address stage moved during a stall");

  // a result appears only from a read in the previous cycle
  a_src: assert property (@(posedge clk) disable iff (rst)
    $rose(ovalid) |-> $past(va && rd_a))
    else $error("result without a frame read");

endmodule

`default_nettype wire

FILE: tb/tb_lidar_point_camera_projector.sv
// tb_lidar_point_camera_projector: self-checking bench for the lidar point camera projector
// drives pixel and point requests with random gaps and stalls, predicts every coloured point
// depends on lpcp_pkg and lidar_point_camera_projector
`default_nettype none

module tb_lidar_point_camera_projector;
  timeunit 1ns;
  timeprecision 1ps;
  import lpcp_pkg::*;

  localparam int IMG_W = 640;
  localparam int IMG_H = 480;
  localparam logic [31:0] ONE_Q = 32'h0001_0000;  // 1.0 in q16.16
  localparam logic [63:0] ALL_ONES = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [143:0] s_tdata = '0;
  logic s_tuser = CMD_PIXEL;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [119:0] m_tdata;
  logic cfg_wen = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // own copy of the register bank and of every pixel written so far
  logic [63:0] reg_copy [NUM_REGS];
  logic [23:0] frame_copy [int];
  // expected coloured points in order: blue, green, red, z, y, x from the top
  logic [119:0] coloured_q [$];
  int errors = 0;
  bit quiet = 1'b0;

  lidar_point_camera_projector u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // generous ceiling on the whole run
  initial begin
    #20ms;
    $display("tb_lidar_point_camera_projector: errors");
    $finish;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // coefficient of the projection matrix, q16.16 signed
  function automatic logic signed [31:0] coeff(input int r, input int c);
    logic [63:0] pair;
    pair = reg_copy[r * 2 + c / 2];
    return (c % 2) ? pair[63:32] : pair[31:0];
  endfunction

  function automatic logic signed [127:0] row_sum(input int r, input logic signed [31:0] x,
                                                  input logic signed [31:0] y,
                                                  input logic signed [31:0] z);
    logic signed [63:0] px, py, pz;
    logic signed [127:0] hom;
    px = coeff(r, 0) * x;
    py = coeff(r, 1) * y;
    pz = coeff(r, 2) * z;
    hom = coeff(r, 3);
    return 128'(px) + 128'(py) + 128'(pz) + (hom <<< 16);
  endfunction

  // floor of num/den when it lies in [0, limit), den positive
  function automatic bit pixel_axis(input logic signed [127:0] num,
                                    input logic signed [127:0] den, input int limit,
                                    output int q);
    logic signed [127:0] quo;
    q = 0;
    if (num < 0) return 0;
    if (num >= (den <<< QUOT_BITS)) return 0;
    quo = num / den;
    if (quo >= limit) return 0;
    q = int'(quo);
    return 1;
  endfunction

  function automatic logic [63:0] mag_sq(input logic signed [31:0] v);
    logic [63:0] m;
    m = (v < 0) ? 64'(-65'(v)) : 64'(v);
    return m * m;
  endfunction

  // cone, range window and projection; gives the frame address when the point lands
  function automatic bit project_point(input item_t it, output int addr);
    logic signed [32:0] ay;
    logic [63:0] r2;
    logic signed [127:0] uu, vv, ww;
    int u, v;
    addr = 0;
    ay = (it.y < 0) ? -33'(it.y) : 33'(it.y);
    if (!(it.x > 0 && ay <= 33'(it.x))) return 0;
    r2 = mag_sq(it.x) + mag_sq(it.y) + mag_sq(it.z);
    if (!(reg_copy[REG_MIN_RANGE] < r2 && r2 < reg_copy[REG_MAX_RANGE])) return 0;
    uu = row_sum(0, it.x, it.y, it.z);
    vv = row_sum(1, it.x, it.y, it.z);
    ww = row_sum(2, it.x, it.y, it.z);
    if (ww == 0) return 0;
    if (ww < 0) begin
      uu = -uu;
      vv = -vv;
      ww = -ww;
    end
    if (!pixel_axis(uu, ww, IMG_W, u)) return 0;
    if (!pixel_axis(vv, ww, IMG_H, v)) return 0;
    addr = v * IMG_W + u;
    return 1;
  endfunction

  // update the frame copy and queue the expected point once a request is taken
  function automatic void take_request(input item_t it);
    int addr;
    logic [23:0] px;
    if (it.cmd == CMD_PIXEL) begin
      if (it.row < IMG_H && it.col < IMG_W)
        frame_copy[int'(it.row) * IMG_W + int'(it.col)] = {it.red, it.green, it.blue};
    end else if (project_point(it, addr)) begin
      px = frame_copy[addr];
      coloured_q.insert(coloured_q.size(),
                        {px[7:0], px[15:8], px[23:16], it.z, it.y, it.x});
    end
  endfunction

  // one request on the slave side, gap drawn first, held until taken
  task automatic send_request(input item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.cmd;
    s_tdata  <= {5'b0, it.red, it.green, it.blue, it.col, it.row, it.z, it.y, it.x};
    forever begin
      @(negedge clk);
      if (s_tready) break;
    end
    @(posedge clk);
    take_request(it);
  endtask

  task automatic send_pixel(input int row, input int col);
    item_t it;
    it = '0;
    it.cmd = CMD_PIXEL;
    it.row = 9'(row);
    it.col = 10'(col);
    it.blue = 8'($urandom);
    it.green = 8'($urandom);
    it.red = 8'($urandom);
    send_request(it);
  endtask

  // a point landing on a never written pixel first gets that pixel written
  task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    item_t it;
    int addr;
    it = '0;
    it.cmd = CMD_POINT;
    it.x = x;
    it.y = y;
    it.z = z;
    it.row = 9'($urandom);
    it.col = 10'($urandom);
    it.blue = 8'($urandom);
    it.green = 8'($urandom);
    it.red = 8'($urandom);
    if (project_point(it, addr) && !frame_copy.exists(addr))
      send_pixel(addr / IMG_W, addr % IMG_W);
    send_request(it);
  endtask

  // wait for every expected point, then let in-flight requests without result pass
  task automatic drain();
    s_tvalid <= 1'b0;
    wait (coloured_q.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  // write enable stays high across back to back writes, the caller lowers it
  task automatic write_reg(input int idx, input logic [63:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= CFG_INDEX_W'(idx);
    cfg_data  <= val;
    @(posedge clk);
    reg_copy[idx] = val;
  endtask

  task automatic load_matrix(input logic [31:0] m [12], input logic [63:0] lo,
                             input logic [63:0] hi);
    drain();
    for (int k = 0; k < 6; k++) write_reg(k, {m[2 * k + 1], m[2 * k]});
    write_reg(REG_MIN_RANGE, lo);
    write_reg(REG_MAX_RANGE, hi);
    cfg_wen <= 1'b0;
  endtask

  // master side: random stall before each result, compare field by field
  initial begin
    logic [119:0] got, want;
    int gap;
    wait (!rst);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      forever begin
        @(negedge clk);
        if (m_tvalid) break;
      end
      got = m_tdata;
      @(posedge clk);
      if (coloured_q.size() == 0) begin
        report("unexpected point", got[31:0], '0);
      end else begin
        want = coloured_q.pop_front();
        if (got[31:0] != want[31:0]) report("out_x", got[31:0], want[31:0]);
        if (got[63:32] != want[63:32]) report("out_y", got[63:32], want[63:32]);
        if (got[95:64] != want[95:64]) report("out_z", got[95:64], want[95:64]);
        if (got[103:96] != want[103:96])
          report("out_red", 32'(got[103:96]), 32'(want[103:96]));
        if (got[111:104] != want[111:104])
          report("out_green", 32'(got[111:104]), 32'(want[111:104]));
        if (got[119:112] != want[119:112])
          report("out_blue", 32'(got[119:112]), 32'(want[119:112]));
      end
    end
  end

  // u = y and v = z in whole metres, w constant: pixel edges and quotient signs
  task automatic test_direct_projection();
    logic [31:0] m [12];
    m = '{0, ONE_Q, 0, 0, 0, 0, ONE_Q, 0, 0, 0, 0, ONE_Q};
    load_matrix(m, 64'd0, ALL_ONES);
    send_pixel(0, 0);
    send_pixel(IMG_H - 1, IMG_W - 1);
    send_pixel(IMG_H, 5);      // row beyond the frame, ignored
    send_pixel(511, 1023);     // both beyond the frame
    send_pixel(7, IMG_W);
    send_point(1000 << 16, 0, 0);
    send_point(1000 << 16, -32'sh8000, 0);            // -1 < u < 0
    send_point(1000 << 16, (IMG_W << 16) - 1, (IMG_H << 16) - 1);
    send_point(1000 << 16, IMG_W << 16, 0);
    send_point(1000 << 16, 0, IMG_H << 16);
    send_point(1000 << 16, 0, -1);
    send_point(0, 0, 0);                              // at the origin
    send_point(-5, 0, 0);                             // behind
    send_point(10 << 16, 10 << 16, 3 << 16);          // on the cone edge
    send_point(10 << 16, (10 << 16) + 1, 0);          // just outside the cone
    send_point(10 << 16, -(10 << 16) - 1, 0);
    send_point(32'h7fff_ffff, 0, 0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
  endtask

  // strict bounds of the range window: r2 of (3, 0, 4) is 25 m^2
  task automatic test_range_window();
    logic [31:0] m [12];
    logic [63:0] r2;
    m = '{0, ONE_Q, 0, 0, 0, 0, ONE_Q, 0, 0, 0, 0, ONE_Q};
    r2 = 64'd25 << 32;
    load_matrix(m, r2 - 1, r2 + 1);
    send_point(3 << 16, 0, 4 << 16);
    load_matrix(m, r2, ALL_ONES);
    send_point(3 << 16, 0, 4 << 16);
    load_matrix(m, 64'd0, r2);
    send_point(3 << 16, 0, 4 << 16);
  endtask

  // w follows z, so z = 0 gives a zero w
  task automatic test_zero_w();
    logic [31:0] m [12];
    m = '{ONE_Q, 0, 0, 0, 0, ONE_Q, 0, 0, 0, 0, ONE_Q, 0};
    load_matrix(m, 64'd0, ALL_ONES);
    send_point(5 << 16, 1 << 16, 0);
    send_point(5 << 16, 1 << 16, 1 << 16);
  endtask

  function automatic logic [31:0] spread(input logic [31:0] lim);
    return 32'($signed(64'($urandom_range(0, 2 * lim))) - $signed(64'(lim)));
  endfunction

  // mostly well formed points in front with random pixel writes and noise
  task automatic random_traffic(input int count);
    logic [31:0] x;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: send_pixel($urandom_range(0, 511), $urandom_range(0, 1023));
        3: send_point($urandom, $urandom, $urandom);
        default: begin
          x = $urandom_range(1 << 16, 200 << 16);
          send_point(x, spread(x), spread(x));
        end
      endcase
    end
    quiet = 1'b0;
  endtask

  // pinhole camera looking along x: u = 320 + 320 y/x, v = 240 - 240 z/x
  task automatic test_pinhole(input bit flip_sign);
    logic [31:0] m [12];
    logic [31:0] s;
    s = flip_sign ? -ONE_Q : ONE_Q;
    m = '{320 * s, 320 * s, 0, 0, 240 * s, 0, -240 * s, 0, s, 0, 0, 0};
    load_matrix(m, 64'd1 << 32, 64'd22500 << 32);
    random_traffic(300);
  endtask

  // random coefficients of modest size, whole range window open
  task automatic test_random_matrix();
    logic [31:0] m [12];
    for (int k = 0; k < 12; k++) m[k] = spread(400 << 16);
    m[8] = $urandom_range(1 << 15, 4 << 16);
    load_matrix(m, 64'd0, ALL_ONES);
    random_traffic(300);
  endtask

  // closed range windows and the all-zero bank give no points at all
  task automatic test_closed_settings();
    logic [31:0] m [12];
    for (int k = 0; k < 12; k++) m[k] = $urandom;
    load_matrix(m, ALL_ONES, ALL_ONES);
    random_traffic(60);
    m = '{default: 0};
    load_matrix(m, 64'd0, ALL_ONES);
    random_traffic(60);
    load_matrix(m, 64'd0, 64'd0);
    random_traffic(60);
  endtask

  initial begin
    for (int k = 0; k < NUM_REGS; k++) reg_copy[k] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_direct_projection();
    test_range_window();
    test_zero_w();
    test_pinhole(1'b0);
    test_pinhole(1'b1);
    test_random_matrix();
    test_closed_settings();
    drain();
    if (errors == 0)
      $display("tb_lidar_point_camera_projector: clean");
    else
      $display("tb_lidar_point_camera_projector: errors");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/lpcp_pkg.sv
rtl/lpcp_ram.sv
rtl/lpcp_project.sv
rtl/lpcp_divide.sv
rtl/lidar_point_camera_projector.sv
tb/tb_lidar_point_camera_projector.sv
